>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define BBVP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BBVP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/bbvp_pkg.sv
`default_nettype none

package bbvp_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 280;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PROD_W      = 44;

  localparam logic [31:0] INTERVAL_RESET = 32'd1000000;

  typedef enum logic [1:0] {
    ACT_BLOCK  = 2'd0,
    ACT_CALL   = 2'd1,
    ACT_FINISH = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_TOTALS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_CHECK,
    BK_WALK_RD,
    BK_WALK_MUL,
    BK_WALK_OUT,
    BK_SUMMARY,
    BK_TOTALS
  } back_state_t;

  // One classified event waiting in the queue between front and back.
  typedef struct packed {
    action_t     op;
    logic [4:0]  idx;
    logic [11:0] size;
  } event_t;

  // Result payload; the last member sits in the lowest bits of tdata.
  typedef struct packed {
    logic [63:0] instructions_so_far;
    logic [63:0] calls_at_end;
    logic [63:0] calls_at_start;
    logic [31:0] interval_number;
    logic [47:0] weight;
    logic [4:0]  entry_index;
  } result_t;

endpackage

`default_nettype wire

>>> design/bbvp_front.sv
`default_nettype none

module bbvp_front #(
  parameter int NUM_BLOCKS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [bbvp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 q_valid,
  input  wire logic                            q_ready,
  output bbvp_pkg::event_t                     q_item
);

  bbvp_pkg::event_t                 queue [bbvp_pkg::QUEUE_DEPTH];
  logic [bbvp_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bbvp_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bbvp_pkg::QPTR_W:0]        count;
  logic                             keep;
  logic                             push;
  logic                             pop;
  bbvp_pkg::action_t                act;
  logic [4:0]                       in_idx;
  bbvp_pkg::event_t                 in_event;

  assign act    = bbvp_pkg::action_t'(s_axis_tuser);
  assign in_idx = s_axis_tdata[4:0];

  // Words that cause nothing (unknown action, block out of range) never enter the queue.
  always_comb begin
    unique case (act) inside
      bbvp_pkg::ACT_BLOCK:                       keep = int'(in_idx) < NUM_BLOCKS;
      bbvp_pkg::ACT_CALL, bbvp_pkg::ACT_FINISH:  keep = 1'b1;
      default:                                   keep = 1'b0;
    endcase
  end

  assign in_event.op   = act;
  assign in_event.idx  = in_idx;
  assign in_event.size = s_axis_tdata[16:5];

  assign s_axis_tready = count != (bbvp_pkg::QPTR_W + 1)'(bbvp_pkg::QUEUE_DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign q_valid       = count != '0;
  assign pop           = q_valid && q_ready;
  assign q_item        = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (bbvp_pkg::QPTR_W + 1)'(push) - (bbvp_pkg::QPTR_W + 1)'(pop);
    end
  end

endmodule

`default_nettype wire

>>> design/bbvp_back.sv
`default_nettype none

module bbvp_back #(
  parameter int NUM_BLOCKS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [31:0]                      cfg_wdata,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire bbvp_pkg::event_t                 q_item,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [bbvp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [31:0] INTERVAL_RESET_L = bbvp_pkg::INTERVAL_RESET;

  bbvp_pkg::back_state_t state;
  bbvp_pkg::back_state_t state_next;

  logic [31:0]                interval_length;
  logic [32:0]                pending;
  logic [63:0]                retired_total;
  logic [63:0]                call_count;
  logic [63:0]                call_count_at_start;
  logic [31:0]                intervals_done;

  logic [31:0]                hit_mem  [NUM_BLOCKS];
  logic [11:0]                size_mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0]      hit_valid;
  logic [31:0]                hit_rdata;
  logic [11:0]                size_rdata;
  logic [IDX_W-1:0]           rd_addr;

  logic [IDX_W-1:0]           cur_idx;
  logic [11:0]                cur_size;
  logic [IDX_W-1:0]           walk_idx;
  logic [bbvp_pkg::PROD_W-1:0] product;

  bbvp_pkg::result_t          result;
  bbvp_pkg::result_t          result_next;
  bbvp_pkg::kind_t            kind;
  bbvp_pkg::kind_t            kind_next;
  logic                       last_next;

  logic                       slot_free;
  logic                       out_load;
  logic                       take_event;
  logic                       do_call;
  logic                       do_update;
  logic                       walk_start;
  logic                       walk_step;
  logic                       dump_commit;

  logic [31:0]                hit_old;
  logic [31:0]                hit_new;
  logic [33:0]                pend_sum;
  logic [32:0]                pend_sat;
  logic                       walk_last;
  logic [63:0]                instr_total;

  assign slot_free   = !m_axis_tvalid || m_axis_tready;
  assign rd_addr     = (state == bbvp_pkg::BK_IDLE) ? IDX_W'(q_item.idx) : walk_idx;
  // An entry without its valid bit has not been hit since the last dump.
  assign hit_old     = hit_valid[cur_idx] ? hit_rdata : '0;
  assign hit_new     = (hit_old == '1) ? hit_old : hit_old + 32'd1;
  assign pend_sum    = {1'b0, pending} + 34'(cur_size);
  assign pend_sat    = pend_sum[33] ? '1 : pend_sum[32:0];
  assign walk_last   = walk_idx == IDX_W'(NUM_BLOCKS - 1);
  assign instr_total = retired_total + 64'(pending);

  always_comb begin
    state_next  = state;
    q_ready     = 1'b0;
    take_event  = 1'b0;
    do_call     = 1'b0;
    do_update   = 1'b0;
    walk_start  = 1'b0;
    walk_step   = 1'b0;
    dump_commit = 1'b0;
    out_load    = 1'b0;
    result_next = '0;
    kind_next   = bbvp_pkg::KIND_ENTRY;
    last_next   = 1'b0;
    unique case (state)
      bbvp_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          unique case (q_item.op) inside
            bbvp_pkg::ACT_CALL: begin
              do_call = 1'b1;
            end
            bbvp_pkg::ACT_FINISH: begin
              state_next = bbvp_pkg::BK_TOTALS;
            end
            default: begin
              take_event = 1'b1;
              state_next = bbvp_pkg::BK_UPDATE;
            end
          endcase
        end
      end
      bbvp_pkg::BK_UPDATE: begin
        do_update  = 1'b1;
        state_next = bbvp_pkg::BK_CHECK;
      end
      bbvp_pkg::BK_CHECK: begin
        if (pending >= {1'b0, interval_length}) begin
          walk_start = 1'b1;
          state_next = bbvp_pkg::BK_WALK_RD;
        end else begin
          state_next = bbvp_pkg::BK_IDLE;
        end
      end
      bbvp_pkg::BK_WALK_RD: begin
        if (hit_valid[walk_idx]) begin
          state_next = bbvp_pkg::BK_WALK_MUL;
        end else if (walk_last) begin
          state_next = bbvp_pkg::BK_SUMMARY;
        end else begin
          walk_step = 1'b1;
        end
      end
      bbvp_pkg::BK_WALK_MUL: begin
        state_next = bbvp_pkg::BK_WALK_OUT;
      end
      bbvp_pkg::BK_WALK_OUT: begin
        result_next.entry_index = 5'(walk_idx);
        result_next.weight      = 48'(product);
        kind_next               = bbvp_pkg::KIND_ENTRY;
        if (slot_free) begin
          out_load = 1'b1;
          if (walk_last) begin
            state_next = bbvp_pkg::BK_SUMMARY;
          end else begin
            walk_step  = 1'b1;
            state_next = bbvp_pkg::BK_WALK_RD;
          end
        end
      end
      bbvp_pkg::BK_SUMMARY: begin
        result_next.interval_number     = intervals_done;
        result_next.calls_at_start      = call_count_at_start;
        result_next.calls_at_end        = call_count;
        result_next.instructions_so_far = instr_total;
        kind_next                       = bbvp_pkg::KIND_SUMMARY;
        last_next                       = 1'b1;
        if (slot_free) begin
          out_load    = 1'b1;
          dump_commit = 1'b1;
          state_next  = bbvp_pkg::BK_IDLE;
        end
      end
      bbvp_pkg::BK_TOTALS: begin
        result_next.interval_number     = intervals_done;
        result_next.calls_at_start      = call_count_at_start;
        result_next.calls_at_end        = call_count;
        result_next.instructions_so_far = instr_total;
        kind_next                       = bbvp_pkg::KIND_TOTALS;
        last_next                       = 1'b1;
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = bbvp_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = bbvp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbvp_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      hit_mem[cur_idx]  <= hit_new;
      size_mem[cur_idx] <= cur_size;
    end
    hit_rdata  <= hit_mem[rd_addr];
    size_rdata <= size_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length     <= INTERVAL_RESET_L;
      pending             <= '0;
      retired_total       <= '0;
      call_count          <= '0;
      call_count_at_start <= '0;
      intervals_done      <= '0;
      hit_valid           <= '0;
      m_axis_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        interval_length <= cfg_wdata;
      end
      if (do_call) begin
        call_count <= call_count + 64'd1;
      end
      if (do_update) begin
        hit_valid[cur_idx] <= 1'b1;
        pending            <= pend_sat;
      end
      if (dump_commit) begin
        call_count_at_start <= call_count;
        retired_total       <= instr_total;
        pending             <= pending - {1'b0, interval_length};
        intervals_done      <= intervals_done + 32'd1;
        hit_valid           <= '0;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_event) begin
      cur_idx  <= IDX_W'(q_item.idx);
      cur_size <= q_item.size;
    end
    if (walk_start) begin
      walk_idx <= '0;
    end else if (walk_step) begin
      walk_idx <= walk_idx + 1'b1;
    end
    if (state == bbvp_pkg::BK_WALK_MUL) begin
      product <= bbvp_pkg::PROD_W'(hit_rdata) * bbvp_pkg::PROD_W'(size_rdata);
    end
    if (out_load) begin
      result       <= result_next;
      kind         <= kind_next;
      m_axis_tlast <= last_next;
    end
  end

  assign m_axis_tdata = {(bbvp_pkg::OUT_TDATA_W - $bits(bbvp_pkg::result_t))'(0), result};
  assign m_axis_tuser = kind;

endmodule

`default_nettype wire

>>> design/basic_block_vector_profiler_core.sv
`default_nettype none

// Basic block vector profiler. Words on the slave side carry an action in
// tuser (block executed, function call, finish) and, for a block, its index
// and size in tdata. A front end takes a word whenever its four-word queue has
// room and drops words that cause nothing; the back end then executes events
// one at a time. A function call only counts the call; a block event goes
// through table read, counter update and interval compare; and a finish
// waits for the output register. When an interval completes, the back
// end walks the hit table: a block not hit takes only a table read, a hit
// block a table read, a multiply and an output, then the summary follows. The
// block that closes the interval is always hit, and a dump waits whenever
// the master side stalls. Results leave through a single output register;
// tuser is the kind and tlast marks the last word of each run. The user must
// write the interval length through cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module basic_block_vector_profiler_core #(
  parameter int NUM_BLOCKS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [31:0]                      cfg_wdata,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: block_index[4:0], block_size[16:5], zero fill [23:17]
  input  wire logic [bbvp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]                       s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata: entry_index[4:0], weight[52:5], interval_number[84:53],
  // calls_at_start[148:85], calls_at_end[212:149],
  // instructions_so_far[276:213], zero fill [279:277]
  output logic [bbvp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tuser: kind[1:0]
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  logic             q_valid;
  logic             q_ready;
  bbvp_pkg::event_t q_item;

  bbvp_front #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  bbvp_back #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> design/bbvp_checker.sv
`default_nettype none

`include "assert_macros.svh"

module bbvp_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [bbvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                       m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  // A stalled word keeps its contents until it is taken.
  `BBVP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed while stalled")

  // Every run ends with a summary or totals word, and only those end a run.
  `BBVP_ASSERT(a_last_kind, m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != bbvp_pkg::KIND_ENTRY)), "tlast does not match the word kind")

  // A vector entry carries only its index and weight.
  `BBVP_ASSERT(a_entry_zero, m_axis_tvalid && m_axis_tuser == bbvp_pkg::KIND_ENTRY |-> m_axis_tdata[279:53] == '0, "vector entry has nonzero summary fields")

  // Nothing is offered in the cycle after a reset edge.
  `BBVP_ASSERT_ALWAYS(a_rst_quiet, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind basic_block_vector_profiler_core bbvp_checker u_bbvp_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire

>>> tb/sv/bbv_profile_checker.sv
module bbv_profile_checker #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [31:0]                      cfg_wdata,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  // tdata: block_index[4:0], block_size[16:5], zero fill [23:17]
  input  logic [bbvp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: entry_index, weight, interval_number, calls_at_start, calls_at_end,
  // instructions_so_far, zero fill
  input  logic [bbvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]                       m_axis_tuser,
  input  logic                             m_axis_tlast,
  output int                               mismatches,
  output int                               words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [32:0] PENDING_MAX = '1;

  typedef struct packed {
    bbvp_pkg::kind_t   kind;
    bbvp_pkg::result_t body;
    logic              last;
  } profile_word_t;

  profile_word_t due_words[$];

  logic [31:0] interval_len;
  logic [31:0] hit_count [NUM_BLOCKS];
  logic [11:0] last_size [NUM_BLOCKS];
  logic [32:0] pending_insns;
  logic [63:0] retired_insns;
  logic [63:0] call_count;
  logic [63:0] calls_at_interval_start;
  logic [31:0] intervals_done;

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report(name, got, want);
    end
  endtask

  // Summary and totals words share their layout; only the kind differs.
  task automatic push_interval_word(bbvp_pkg::kind_t k);
    profile_word_t w;
    w = '0;
    w.kind = k;
    w.body.interval_number = intervals_done;
    w.body.calls_at_start = calls_at_interval_start;
    w.body.calls_at_end = call_count;
    w.body.instructions_so_far = retired_insns + 64'(pending_insns);
    w.last = 1'b1;
    due_words.push_back(w);
  endtask

  task automatic advance_profile(logic [1:0] op, logic [4:0] idx, logic [11:0] size);
    profile_word_t w;
    logic [33:0]   sum;
    logic [63:0]   product;
    case (op)
      bbvp_pkg::ACT_CALL: begin
        call_count++;
      end
      bbvp_pkg::ACT_FINISH: begin
        push_interval_word(bbvp_pkg::KIND_TOTALS);
      end
      bbvp_pkg::ACT_BLOCK: begin
        if (idx < NUM_BLOCKS) begin
          last_size[idx] = size;
          if (hit_count[idx] != '1) begin
            hit_count[idx]++;
          end
          sum = 34'(pending_insns) + 34'(size);
          pending_insns = (sum > 34'(PENDING_MAX)) ? PENDING_MAX : sum[32:0];
          if (pending_insns >= 33'(interval_len)) begin
            for (int i = 0; i < NUM_BLOCKS; i++) begin
              if (hit_count[i] != 0) begin
                product = 64'(hit_count[i]) * 64'(last_size[i]);
                w = '0;
                w.kind = bbvp_pkg::KIND_ENTRY;
                w.body.entry_index = 5'(i);
                w.body.weight = product[47:0];
                due_words.push_back(w);
              end
              hit_count[i] = '0;
            end
            push_interval_word(bbvp_pkg::KIND_SUMMARY);
            // The excess over the interval carries into the next one.
            calls_at_interval_start = call_count;
            retired_insns += 64'(pending_insns);
            pending_insns -= 33'(interval_len);
            intervals_done++;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    profile_word_t     want;
    bbvp_pkg::result_t got;
    if (rst) begin
      interval_len = bbvp_pkg::INTERVAL_RESET;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        hit_count[i] = '0;
        last_size[i] = '0;
      end
      pending_insns = '0;
      retired_insns = '0;
      call_count = '0;
      calls_at_interval_start = '0;
      intervals_done = '0;
      due_words.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = bbvp_pkg::result_t'(m_axis_tdata[$bits(bbvp_pkg::result_t)-1:0]);
        if (due_words.size() == 0) begin
          report("result word with nothing expected, kind", 64'(m_axis_tuser), 64'(0));
        end else begin
          want = due_words.pop_front();
          compare_field("kind", 64'(m_axis_tuser), 64'(want.kind));
          compare_field("entry_index", 64'(got.entry_index), 64'(want.body.entry_index));
          compare_field("weight", 64'(got.weight), 64'(want.body.weight));
          compare_field("interval_number", 64'(got.interval_number),
                        64'(want.body.interval_number));
          compare_field("calls_at_start", got.calls_at_start, want.body.calls_at_start);
          compare_field("calls_at_end", got.calls_at_end, want.body.calls_at_end);
          compare_field("instructions_so_far", got.instructions_so_far,
                        want.body.instructions_so_far);
          compare_field("last", 64'(m_axis_tlast), 64'(want.last));
        end
      end
      if (cfg_we) begin
        interval_len = cfg_wdata;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_profile(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[16:5]);
      end
    end
    // Published through a nonblocking assignment so that the stimulus side never races the update.
    words_due <= due_words.size();
  end

endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_BLOCKS   = 32;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          CONFIG_PAUSE = 40;
  localparam int          FINAL_PAUSE  = 200;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam logic [11:0] SIZE_MAX     = 12'hFFF;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [31:0]                      cfg_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [bbvp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [bbvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]                       m_axis_tuser;
  logic                             m_axis_tlast;

  int mismatches;
  int words_due;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm_source = 1'b0;
  bit calm_sink = 1'b0;

  always #5 clk = ~clk;

  basic_block_vector_profiler_core #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  bbv_profile_checker #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) profile_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .mismatches(mismatches),
    .words_due(words_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm_sink && $urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(logic [1:0] op, logic [4:0] idx, logic [11:0] size);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (calm_source || r < 60) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= bbvp_pkg::IN_TDATA_W'({size, idx});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Waits until every predicted word has come out, then lets the block settle.
  task automatic wait_idle(int extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_interval(logic [31:0] len);
    wait_idle(CONFIG_PAUSE);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] len, int words, bit calm);
    int          counted;
    int          r;
    logic [11:0] size;
    counted = 0;
    write_interval(len);
    calm_source = calm;
    calm_sink = calm;
    while (counted < words) begin
      r = $urandom_range(0, 99);
      size = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(1, 16))
                                         : 12'($urandom_range(1, 4095));
      if (r < 72) begin
        send_word(bbvp_pkg::ACT_BLOCK, 5'($urandom_range(0, NUM_BLOCKS - 1)), size);
        counted++;
      end else if (r < 86) begin
        send_word(bbvp_pkg::ACT_CALL, 5'($urandom), size);
        counted++;
      end else if (r < 95) begin
        send_word(bbvp_pkg::ACT_FINISH, 5'($urandom), size);
        counted++;
      end else begin
        send_word(ACT_UNUSED, 5'($urandom), size);
      end
    end
    calm_source = 1'b0;
    calm_sink = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset interval length: nothing dumps, totals start from zero.
    send_word(bbvp_pkg::ACT_FINISH, 5'd0, 12'd0);
    send_word(bbvp_pkg::ACT_CALL, 5'd0, 12'd0);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd0, 12'd1);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd31, SIZE_MAX);
    send_word(ACT_UNUSED, 5'd31, SIZE_MAX);
    send_word(bbvp_pkg::ACT_CALL, 5'd0, 12'd0);
    send_word(bbvp_pkg::ACT_FINISH, 5'd0, 12'd0);

    // Shortest nonzero interval: the pending count stays above it after each dump.
    write_interval(32'd1);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd10, 12'hAAA);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd21, 12'h555);
    send_word(bbvp_pkg::ACT_CALL, 5'd0, 12'd0);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd21, 12'd1);
    send_word(bbvp_pkg::ACT_FINISH, 5'd0, 12'd0);

    // Zero length dumps on every block word and subtracts nothing.
    write_interval(32'd0);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd0, SIZE_MAX);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd0, SIZE_MAX);
    send_word(bbvp_pkg::ACT_FINISH, 5'd0, 12'd0);

    write_interval(32'hFFFF_FFFF);
    send_word(bbvp_pkg::ACT_BLOCK, 5'd7, SIZE_MAX);
    send_word(bbvp_pkg::ACT_CALL, 5'd0, 12'd0);
    send_word(bbvp_pkg::ACT_FINISH, 5'd0, 12'd0);

    run_phase(32'($urandom_range(1, 4000)), 35, 1'b0);
    run_phase(32'($urandom_range(4000, 60000)), 35, 1'b1);
    run_phase(32'($urandom_range(1, 200)), 35, 1'b0);
    run_phase(32'($urandom_range(20000, 120000)), 35, 1'b0);

    wait_idle(FINAL_PAUSE);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> basic_block_vector_profiler_core.f
+incdir+design
design/bbvp_pkg.sv
design/bbvp_front.sv
design/bbvp_back.sv
design/basic_block_vector_profiler_core.sv
design/bbvp_checker.sv
tb/sv/bbv_profile_checker.sv
tb/sv/tb.sv
